// ===== hdl/dual_pad_click_gesture_decoder_assert.svh =====
// assertion macros for the click gesture decoder checker
`ifndef DUAL_PAD_CLICK_GESTURE_DECODER_ASSERT_SVH
`define DUAL_PAD_CLICK_GESTURE_DECODER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define DPCG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DPCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dpcg_pkg.sv =====
package dpcg_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STAMP_IN_BITS = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CLICK_GAP,
        CFG_DBL_WINDOW,
        CFG_CROSS_GUARD,
        CFG_TOGGLE_LOCKOUT
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] CLICK_GAP_RESET      = 16'd500;
    localparam logic [CFG_WIDTH-1:0] DBL_WINDOW_RESET     = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] CROSS_GUARD_RESET    = 16'd250;
    localparam logic [CFG_WIDTH-1:0] TOGGLE_LOCKOUT_RESET = 16'd500;

    localparam logic [1:0] TALLY_CLEAR  = 2'd0;
    localparam logic [1:0] TALLY_FIRST  = 2'd1;
    localparam logic [1:0] TALLY_DOUBLE = 2'd2;
    localparam logic [1:0] TALLY_MAX    = 2'd3;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] click_gap;
        logic [CFG_WIDTH-1:0] dbl_window;
        logic [CFG_WIDTH-1:0] cross_guard;
        logic [CFG_WIDTH-1:0] toggle_lockout;
    } cfg_t;

    typedef struct packed {
        logic                     pad_select;
        logic                     first_button;
        logic                     second_button;
        logic [1:0]               buttons_present;
        logic [STAMP_IN_BITS-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic base_mode;
        logic right_precision;
        logic left_precision;
        logic mode_switched;
        logic right_toggled;
        logic left_toggled;
    } result_t;

endpackage

// ===== hdl/dpcg_engine.sv =====
module dpcg_engine
    import dpcg_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic [TIME_BITS-1:0] stamp_reg [4];
    logic [TIME_BITS-1:0] stamp_next [4];
    logic [1:0]           tally_reg [4];
    logic [1:0]           tally_next [4];
    logic [3:0]           pressed_reg;
    logic [3:0]           pressed_next;
    logic                 mode_reg;
    logic                 mode_next;
    logic [1:0]           fine_reg;
    logic [1:0]           fine_next;
    logic [TIME_BITS-1:0] tog_stamp_reg [2];
    logic [TIME_BITS-1:0] tog_stamp_next [2];

    logic [TIME_BITS+STAMP_IN_BITS-1:0] now_ext;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] gap_d [4];
    logic [TIME_BITS-1:0] age_d [4];
    logic [TIME_BITS-1:0] lock_d [2];
    logic [TIME_BITS-1:0] gap_lim;
    logic [TIME_BITS-1:0] win_lim;
    logic [TIME_BITS-1:0] guard_lim;
    logic [TIME_BITS-1:0] lock_lim;
    logic [3:0]           present;
    logic [3:0]           level;
    logic [1:0]           dbl;
    logic [1:0]           recent;
    logic [1:0]           lock_ok;

    assign now_ext   = {{TIME_BITS{1'b0}}, item.time_ms};
    assign now       = now_ext[TIME_BITS-1:0];
    assign gap_lim   = TIME_BITS'(cfg.click_gap);
    assign win_lim   = TIME_BITS'(cfg.dbl_window);
    assign guard_lim = TIME_BITS'(cfg.cross_guard);
    assign lock_lim  = TIME_BITS'(cfg.toggle_lockout);

    // per-button edge detect and click series
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            present[k] = (item.pad_select == k[1]) &&
                         (k[0] ? item.buttons_present[1] : (item.buttons_present != 2'd0));
            level[k]   = k[0] ? item.second_button : item.first_button;
            gap_d[k]   = now - stamp_reg[k];
            stamp_next[k]   = stamp_reg[k];
            pressed_next[k] = pressed_reg[k];
            tally_next[k]   = tally_reg[k];
            if (present[k])
            begin
                if (level[k] && !pressed_reg[k])
                begin
                    if (gap_d[k] > gap_lim)
                    begin
                        tally_next[k] = TALLY_FIRST;
                    end
                    else if (tally_reg[k] != TALLY_MAX)
                    begin
                        tally_next[k] = tally_reg[k] + 2'd1;
                    end
                    stamp_next[k] = now;
                end
                pressed_next[k] = level[k];
            end
            age_d[k] = now - stamp_next[k];
        end

        for (int p = 0; p < 2; p++)
        begin
            dbl[p] = (tally_next[2*p] >= TALLY_DOUBLE) && (tally_next[2*p+1] >= TALLY_DOUBLE) &&
                     (age_d[2*p] < win_lim) && (age_d[2*p+1] < win_lim);
            recent[p]  = (age_d[2*p] < guard_lim) || (age_d[2*p+1] < guard_lim);
            lock_d[p]  = now - tog_stamp_reg[p];
            lock_ok[p] = lock_d[p] > lock_lim;
            tog_stamp_next[p] = tog_stamp_reg[p];
        end

        mode_next = mode_reg;
        fine_next = fine_reg;
        result.mode_switched = 1'b0;
        result.right_toggled = 1'b0;
        result.left_toggled  = 1'b0;

        priority if (dbl[0] && dbl[1])
        begin
            mode_next = ~mode_reg;
            result.mode_switched = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                tally_next[k] = TALLY_CLEAR;
            end
        end
        else if (dbl[0] && !recent[1] && lock_ok[0])
        begin
            fine_next[0] = ~fine_reg[0];
            tog_stamp_next[0] = now;
            result.right_toggled = 1'b1;
            tally_next[0] = TALLY_CLEAR;
            tally_next[1] = TALLY_CLEAR;
        end
        else if (!dbl[0] && dbl[1] && !recent[0] && lock_ok[1])
        begin
            fine_next[1] = ~fine_reg[1];
            tog_stamp_next[1] = now;
            result.left_toggled = 1'b1;
            tally_next[2] = TALLY_CLEAR;
            tally_next[3] = TALLY_CLEAR;
        end
        else
        begin
            mode_next = mode_reg;
        end

        result.base_mode       = mode_next;
        result.right_precision = fine_next[0];
        result.left_precision  = fine_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                stamp_reg[k] <= '0;
                tally_reg[k] <= TALLY_CLEAR;
            end
            pressed_reg <= '0;
            mode_reg    <= 1'b0;
            fine_reg    <= '0;
            tog_stamp_reg[0] <= '0;
            tog_stamp_reg[1] <= '0;
        end
        else if (advance)
        begin
            for (int k = 0; k < 4; k++)
            begin
                stamp_reg[k] <= stamp_next[k];
                tally_reg[k] <= tally_next[k];
            end
            pressed_reg <= pressed_next;
            mode_reg    <= mode_next;
            fine_reg    <= fine_next;
            tog_stamp_reg[0] <= tog_stamp_next[0];
            tog_stamp_reg[1] <= tog_stamp_next[1];
        end
    end

endmodule

// ===== hdl/dual_pad_click_gesture_decoder.sv =====
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   pad_select first_button second_button
//                                          buttons_present time_ms
// out       output     out_valid/out_stall base_mode right_precision left_precision
//                                          mode_switched right_toggled left_toggled
// cfg       input      cfg_write           cfg_index cfg_data
//
// one transaction per cycle sustained while out_stall stays low; a result passes from its input
// transaction through the input register, the decode logic and then the result register
// rst_n clears gesture state and loads the register defaults; no clearing pass
// out_stall backs up into in_stall only when both the result and input registers are full
module dual_pad_click_gesture_decoder
    import dpcg_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      pad_select,
    input  logic                      first_button,
    input  logic                      second_button,
    input  logic [1:0]                buttons_present,
    input  logic [STAMP_IN_BITS-1:0]  time_ms,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      base_mode,
    output logic                      right_precision,
    output logic                      left_precision,
    output logic                      mode_switched,
    output logic                      right_toggled,
    output logic                      left_toggled,

    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t result_reg;
    result_t result_next;
    result_t result;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    advance;
    logic    in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CLICK_GAP:      cfg_next.click_gap      = cfg_data;
                CFG_DBL_WINDOW:     cfg_next.dbl_window     = cfg_data;
                CFG_CROSS_GUARD:    cfg_next.cross_guard    = cfg_data;
                CFG_TOGGLE_LOCKOUT: cfg_next.toggle_lockout = cfg_data;
            endcase
        end
    end

    always_comb
    begin
        item_next = item_reg;
        if (in_fire)
        begin
            item_next.pad_select      = pad_select;
            item_next.first_button    = first_button;
            item_next.second_button   = second_button;
            item_next.buttons_present = buttons_present;
            item_next.time_ms         = time_ms;
        end
        in_valid_next  = in_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
        result_next    = advance ? result : result_reg;
    end

    dpcg_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_gap      <= CLICK_GAP_RESET;
            cfg_reg.dbl_window     <= DBL_WINDOW_RESET;
            cfg_reg.cross_guard    <= CROSS_GUARD_RESET;
            cfg_reg.toggle_lockout <= TOGGLE_LOCKOUT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign base_mode       = result_reg.base_mode;
    assign right_precision = result_reg.right_precision;
    assign left_precision  = result_reg.left_precision;
    assign mode_switched   = result_reg.mode_switched;
    assign right_toggled   = result_reg.right_toggled;
    assign left_toggled    = result_reg.left_toggled;

endmodule

// ===== hdl/dpcg_checker.sv =====
`include "dual_pad_click_gesture_decoder_assert.svh"

module dpcg_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic base_mode,
    input logic right_precision,
    input logic left_precision,
    input logic mode_switched,
    input logic right_toggled,
    input logic left_toggled
);

    logic out_fire;
    logic last_mode_reg;
    logic last_right_reg;
    logic last_left_reg;

    assign out_fire = out_valid && !out_stall;

    // flags as of the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mode_reg  <= 1'b0;
            last_right_reg <= 1'b0;
            last_left_reg  <= 1'b0;
        end
        else if (out_fire)
        begin
            last_mode_reg  <= base_mode;
            last_right_reg <= right_precision;
            last_left_reg  <= left_precision;
        end
    end

    `DPCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(base_mode) && $stable(right_precision) &&
        $stable(left_precision) && $stable(mode_switched) &&
        $stable(right_toggled) && $stable(left_toggled),
        "stalled result changed")
    `DPCG_ASSERT_IMP(a_one_event, out_valid,
        $onehot0({mode_switched, right_toggled, left_toggled}),
        "more than one gesture event in one result")
    `DPCG_ASSERT_IMP(a_mode_track, out_fire,
        (base_mode ^ last_mode_reg) == mode_switched,
        "mode changed without mode_switched")
    `DPCG_ASSERT_IMP(a_right_track, out_fire,
        (right_precision ^ last_right_reg) == right_toggled,
        "right precision changed without right_toggled")
    `DPCG_ASSERT_IMP(a_left_track, out_fire,
        (left_precision ^ last_left_reg) == left_toggled,
        "left precision changed without left_toggled")

endmodule

bind dual_pad_click_gesture_decoder dpcg_checker u_dpcg_checker (.*);
